>>> src/clook_pkg.sv
// Shared types and constants for the C-LOOK scheduler.
package clook_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int MAX_TRACK    = 1023;
  localparam int TRACK_W      = 10;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int SEEK_W       = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DIR  = CFG_IDX_W'(1);

  typedef logic [TRACK_W-1:0] track_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS,
    OP_ROT,
    OP_SHL,
    OP_POP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    track_t   key;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROTATE,
    ST_SEEK,
    ST_EMIT
  } state_e;

  // Saturate a track to the highest track of the drive.
  function automatic track_t clamp_track(input track_t v);
    clamp_track = (32'(v) > MAX_TRACK) ? TRACK_W'(MAX_TRACK) : v;
  endfunction

endpackage

>>> src/clook_cell.sv
// One storage cell of the sorted request chain.
module clook_cell
  import clook_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  track_t    left_val_i,
  input  logic      left_valid_i,
  input  logic      left_gt_i,
  input  track_t    right_val_i,
  input  logic      right_valid_i,
  input  track_t    head_val_i,
  output track_t    val_o,
  output logic      valid_o,
  output logic      gt_o
);

  track_t val_q, val_d;
  logic   valid_q, valid_d;

  // empty cells count as larger than any key
  assign gt_o    = !valid_q || (val_q > ctl_i.key);
  assign val_o   = val_q;
  assign valid_o = valid_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    case (ctl_i.op)
      OP_INS: begin
        if (gt_o) begin
          val_d = left_gt_i ? left_val_i : ctl_i.key;
        end
        valid_d = valid_q | left_valid_i;
      end
      OP_ROT: begin
        if (valid_q) begin
          val_d = right_valid_i ? right_val_i : head_val_i;
        end
      end
      OP_SHL: begin
        val_d   = right_val_i;
        valid_d = right_valid_i;
      end
      OP_POP: begin
        valid_d = valid_q & right_valid_i;
      end
      default: begin
        val_d   = val_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> src/clook_chain.sv
// Row of cells holding the requests in ascending order.
module clook_chain
  import clook_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  output track_t    first_val_o,
  output track_t    top_val_o
);

  track_t                  val_w    [MAX_REQUESTS];
  track_t                  lval_w   [MAX_REQUESTS];
  track_t                  rval_w   [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] valid_w;
  logic [MAX_REQUESTS-1:0] gt_w;
  logic [MAX_REQUESTS-1:0] lvalid_w;
  logic [MAX_REQUESTS-1:0] lgt_w;
  logic [MAX_REQUESTS-1:0] rvalid_w;
  logic [MAX_REQUESTS-1:0] top_w;

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    if (i == 0) begin : g_left_end
      assign lval_w[i]   = '0;
      assign lvalid_w[i] = 1'b1;
      assign lgt_w[i]    = 1'b0;
    end else begin : g_left
      assign lval_w[i]   = val_w[i-1];
      assign lvalid_w[i] = valid_w[i-1];
      assign lgt_w[i]    = gt_w[i-1];
    end

    if (i == MAX_REQUESTS - 1) begin : g_right_end
      assign rval_w[i]   = '0;
      assign rvalid_w[i] = 1'b0;
    end else begin : g_right
      assign rval_w[i]   = val_w[i+1];
      assign rvalid_w[i] = valid_w[i+1];
    end

    // highest occupied cell
    assign top_w[i] = valid_w[i] & ~rvalid_w[i];

    clook_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .left_val_i   (lval_w[i]),
      .left_valid_i (lvalid_w[i]),
      .left_gt_i    (lgt_w[i]),
      .right_val_i  (rval_w[i]),
      .right_valid_i(rvalid_w[i]),
      .head_val_i   (val_w[0]),
      .val_o        (val_w[i]),
      .valid_o      (valid_w[i]),
      .gt_o         (gt_w[i])
    );
  end

  assign first_val_o = val_w[0];

  always_comb begin
    top_val_o = '0;
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      top_val_o = top_val_o | ({TRACK_W{top_w[i]}} & val_w[i]);
    end
  end

endmodule

>>> src/clook_disk_scheduler_top.sv
// Top level of the C-LOOK disk scheduler: control, seek sum and output stage.
//
// Channel  | Dir | Handshake            | Beat payload
// ---------+-----+----------------------+---------------------------------------------
// in       | in  | in_valid_i/in_ready_o | track_i, last_request_i
// out      | out | out_valid_o/out_ready_i | served_track_o, total_seek_o, overflow_o,
//          |     |                      | last_served_o
// cfg      | in  | cfg_we_i             | cfg_idx_i, cfg_wdata_i (0 start_head, 1 sweep_dir)
//
// Requests are taken one per cycle while in_ready_o is high; each insert shifts the larger
// entries up one cell. After the last request the entries behind the split point are rotated
// to the back (ST_ROTATE), the seek sum is registered (ST_SEEK), then one result beat per
// cycle is loaded while out_ready_i stays high (ST_EMIT).
// in_ready_o is low from the last request until the final result is loaded.
// Reset empties the chain and sets start_head to 0 and sweep_dir to 1.
// A stall on the output holds the result register; the chain waits behind it.
module clook_disk_scheduler_top
  import clook_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TRACK_W-1:0]    track_i,
  input  logic                  last_request_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TRACK_W-1:0]    served_track_o,
  output logic [SEEK_W-1:0]     total_seek_o,
  output logic                  overflow_o,
  output logic                  last_served_o
);

  state_e state_q, state_d;

  // configuration
  track_t start_head_q;
  logic   sweep_dir_q;

  // batch bookkeeping
  logic [CNT_W-1:0] cnt_q;     // stored requests
  logic [CNT_W-1:0] rot_q;     // rotations done, ends as the split point
  logic [CNT_W-1:0] rem_q;     // results still to load
  logic             dropped_q;
  track_t           min_q, max_q;
  track_t           bnd_q;     // track next to the split, used by the seek sum
  logic [SEEK_W-1:0] seek_q;

  // output stage
  logic              out_valid_q;
  track_t            out_track_q;
  logic [SEEK_W-1:0] out_seek_q;
  logic              out_ovf_q;
  logic              out_last_q;

  cell_ctl_t ctl;
  track_t    first_val, top_val;
  track_t    head, key;
  logic      in_acc, full, below, rot_go, load;

  assign head   = clamp_track(start_head_q);
  assign key    = clamp_track(track_i);
  assign in_acc = in_valid_i && in_ready_o;
  assign full   = (cnt_q == CNT_W'(MAX_REQUESTS));
  // front entry still belongs behind the split
  assign below  = sweep_dir_q ? (first_val < head) : (first_val <= head);
  assign rot_go = below && (rot_q != cnt_q);
  assign load   = !out_valid_q || out_ready_i;

  clook_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .first_val_o(first_val),
    .top_val_o  (top_val)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: if (in_acc && last_request_i) state_d = ST_ROTATE;
      ST_ROTATE:  if (!rot_go) state_d = ST_SEEK;
      ST_SEEK:    state_d = ST_EMIT;
      ST_EMIT:    if (load && rem_q == CNT_W'(1)) state_d = ST_COLLECT;
      default:    state_d = ST_COLLECT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    ctl.op     = OP_HOLD;
    ctl.key    = key;
    case (state_q)
      ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_acc && !full) ctl.op = OP_INS;
      end
      ST_ROTATE: begin
        if (rot_go) ctl.op = OP_ROT;
      end
      ST_EMIT: begin
        if (load) ctl.op = sweep_dir_q ? OP_SHL : OP_POP;
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

  // seek sum, split cases: no entries below, no entries above, or a wrap
  logic [SEEK_W-1:0] d_mh, d_mm, d_hm, d_bmin, d_maxb, seek_d;
  logic split0, splitn;

  assign d_mh   = SEEK_W'(max_q - head);
  assign d_mm   = SEEK_W'(max_q - min_q);
  assign d_hm   = SEEK_W'(head - min_q);
  assign d_bmin = SEEK_W'(bnd_q - min_q);
  assign d_maxb = SEEK_W'(max_q - bnd_q);
  assign split0 = (rot_q == '0);
  assign splitn = (rot_q == cnt_q);

  always_comb begin
    if (sweep_dir_q) begin
      if (split0)      seek_d = d_mh;
      else if (splitn) seek_d = d_hm + d_mm;
      else             seek_d = d_mh + d_mm + d_bmin;
    end else begin
      if (splitn)      seek_d = d_hm;
      else if (split0) seek_d = d_mh + d_mm;
      else             seek_d = d_hm + d_mm + d_maxb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_COLLECT;
      start_head_q <= '0;
      sweep_dir_q  <= 1'b1;
      cnt_q        <= '0;
      rot_q        <= '0;
      rem_q        <= '0;
      dropped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_HEAD: start_head_q <= cfg_wdata_i[TRACK_W-1:0];
          CFG_SWEEP_DIR:  sweep_dir_q  <= cfg_wdata_i[0];
          default:        ;
        endcase
      end

      // a new beat is loaded, or the held one leaves
      if (state_q == ST_EMIT && load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_COLLECT: begin
          rot_q <= '0;
          if (in_acc) begin
            if (full) dropped_q <= 1'b1;
            else      cnt_q     <= cnt_q + CNT_W'(1);
          end
        end
        ST_SEEK: begin
          rem_q <= cnt_q;
        end
        ST_ROTATE: begin
          if (rot_go) rot_q <= rot_q + CNT_W'(1);
        end
        ST_EMIT: begin
          if (load) begin
            rem_q <= rem_q - CNT_W'(1);
            if (rem_q == CNT_W'(1)) begin
              cnt_q     <= '0;
              dropped_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_COLLECT: begin
        if (in_acc && !full) begin
          if (cnt_q == '0 || key < min_q) min_q <= key;
          if (cnt_q == '0 || key > max_q) max_q <= key;
        end
      end
      ST_ROTATE: begin
        // upward sweep needs the last entry rotated away,
        // downward sweep the first entry left at the front
        if (rot_go ? sweep_dir_q : !sweep_dir_q) bnd_q <= first_val;
      end
      ST_SEEK: begin
        seek_q <= seek_d;
      end
      ST_EMIT: begin
        if (load) begin
          out_track_q <= sweep_dir_q ? first_val : top_val;
          out_seek_q  <= seek_q;
          out_ovf_q   <= dropped_q;
          out_last_q  <= (rem_q == CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign served_track_o = out_track_q;
  assign total_seek_o   = out_seek_q;
  assign overflow_o     = out_ovf_q;
  assign last_served_o  = out_last_q;

endmodule

>>> src/clook_checker.sv
// Port-level checks for the C-LOOK scheduler, bound to the top level.
module clook_checker
  import clook_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  last_request_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [TRACK_W-1:0]    served_track_o,
  input logic [SEEK_W-1:0]     total_seek_o,
  input logic                  overflow_o,
  input logic                  last_served_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(served_track_o)
      && $stable(total_seek_o) && $stable(overflow_o) && $stable(last_served_o))
    else $error("stalled result beat changed");

  // no intake while a batch is still being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_served_o |-> !in_ready_o)
    else $error("request taken during emission");

  // last request closes the batch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_request_i |=> !in_ready_o)
    else $error("intake open after last request");

  // beats of a batch follow each other with no gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_served_o |=> out_valid_o)
    else $error("gap between result beats of a batch");

endmodule

bind clook_disk_scheduler_top clook_checker u_clook_checker (.*);
